/* design/assert_macros.svh */
// Assertion macros used by the RTL top of the image-map hit-test unit.
// Every macro samples on clock and is switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define ASSERT_AT_CLK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// The condition must never be seen at a sampled edge.
`define ASSERT_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

/* design/ihit_pkg.sv */
// Package of the image-map hit-test unit: sizes, command, shape and status codes.
// Used by ihit_mul, imagemap_area_hit_test_unit and the testbench; depends on nothing.
package ihit_pkg;

   localparam int MAX_AREAS   = 32;
   localparam int MAX_COORDS  = 256;
   localparam int COORD_BITS  = 16;

   localparam int AREA_IDX_W  = $clog2(MAX_AREAS);
   localparam int AREA_CNT_W  = $clog2(MAX_AREAS + 1);
   localparam int COORD_IDX_W = $clog2(MAX_COORDS);
   localparam int COORD_CNT_W = $clog2(MAX_COORDS + 1);
   localparam int VERT_W      = COORD_CNT_W - 1;
   localparam int WIND_W      = VERT_W + 1;
   localparam int PNT_W       = COORD_BITS + 1;
   localparam int DIF_W       = COORD_BITS + 2;
   localparam int PROD_W      = 2 * DIF_W;

   localparam logic [2:0] MODE_CLEAR  = 3'd0;
   localparam logic [2:0] MODE_BEGIN  = 3'd1;
   localparam logic [2:0] MODE_APPEND = 3'd2;
   localparam logic [2:0] MODE_END    = 3'd3;
   localparam logic [2:0] MODE_QUERY  = 3'd4;

   localparam logic [2:0] SC_UNSPEC  = 3'd0;
   localparam logic [2:0] SC_DEFAULT = 3'd1;
   localparam logic [2:0] SC_RECT    = 3'd2;
   localparam logic [2:0] SC_CIRCLE  = 3'd3;
   localparam logic [2:0] SC_POLY    = 3'd4;

   localparam logic [1:0] SH_DEFAULT = 2'd0;
   localparam logic [1:0] SH_RECT    = 2'd1;
   localparam logic [1:0] SH_CIRCLE  = 2'd2;
   localparam logic [1:0] SH_POLY    = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_REJECT = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_NOAREA = 2'd3;

   typedef logic signed [DIF_W-1:0]  dif_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   typedef struct packed {
      logic    en;
      dif_type a;
      dif_type b;
   } mul_req_type;

endpackage

/* design/imagemap_area_hit_test_unit.sv */
// Top level of the image-map hit-test unit: area tables, coordinate memory, query sequencer.
// Depends on ihit_pkg, ihit_mul and assert_macros.svh.
//
//  channel   | ports                    | handshake
//  ----------+--------------------------+-----------------------------------
//  request   | req_*                    | taken when start is high, busy low
//  response  | rsp_*                    | one-cycle strobe rsp_valid
//
// Clear, begin, append, end and a query on an empty table answer in the cycle after
// they are taken; busy stays low. A query walks the areas in order: it reads each
// area's entry, then fetches a rectangle's four coordinates and compares them, or a
// circle's three for a box test and, if that passes, squares and compares, or walks a
// polygon edge by edge, all through one multiplier and one coordinate read port; the response follows.
// Reset is synchronous and empties the table; the response cannot be stalled.
`include "assert_macros.svh"

module imagemap_area_hit_test_unit import ihit_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_mode,
   input  logic [2:0]         req_shape_code,
   input  logic               req_has_link,
   input  logic [15:0]        req_link_id,
   input  logic signed [15:0] req_coord_value,
   input  logic signed [15:0] req_point_x,
   input  logic signed [15:0] req_point_y,
   input  logic signed [15:0] req_offset_x,
   input  logic signed [15:0] req_offset_y,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic               rsp_hit,
   output logic               rsp_hit_has_link,
   output logic [15:0]        rsp_hit_link_id,
   output logic [4:0]         rsp_hit_area_index
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_AREA_RD  = 4'd1;
   localparam logic [3:0] S_AREA     = 4'd2;
   localparam logic [3:0] S_FETCH    = 4'd3;
   localparam logic [3:0] S_RECT     = 4'd4;
   localparam logic [3:0] S_CIRC     = 4'd5;
   localparam logic [3:0] S_MUL_X    = 4'd6;
   localparam logic [3:0] S_MUL_Y    = 4'd7;
   localparam logic [3:0] S_MUL_R    = 4'd8;
   localparam logic [3:0] S_CIRC_CMP = 4'd9;
   localparam logic [3:0] S_PV0      = 4'd10;
   localparam logic [3:0] S_PV       = 4'd11;
   localparam logic [3:0] S_E1       = 4'd12;
   localparam logic [3:0] S_E2       = 4'd13;
   localparam logic [3:0] S_E3       = 4'd14;

   logic [1:0]             shape_mem [MAX_AREAS];
   logic [COORD_IDX_W-1:0] first_mem [MAX_AREAS];
   logic [COORD_CNT_W-1:0] count_mem [MAX_AREAS];
   logic [16:0]            link_mem  [MAX_AREAS];
   logic [COORD_BITS-1:0]  coord_mem [MAX_COORDS];

   logic [3:0]             state_ff, state_in;
   logic [AREA_CNT_W-1:0]  area_total_ff, area_total_in;
   logic [COORD_CNT_W-1:0] coord_fill_ff, coord_fill_in;
   logic                   area_open_ff, area_open_in;
   logic [COORD_CNT_W-1:0] open_first_ff, open_first_in;
   logic [2:0]             pend_code_ff, pend_code_in;

   logic [AREA_CNT_W-1:0]  a_ff, a_in;
   logic [1:0]             ard_shape_ff;
   logic [COORD_IDX_W-1:0] ard_first_ff;
   logic [COORD_CNT_W-1:0] ard_count_ff;
   logic [16:0]            ard_link_ff;
   logic [COORD_IDX_W-1:0] ptr_ff, ptr_in;
   logic [2:0]             left_ff, left_in;
   logic                   pend_ff, pend_in;
   logic [3:0]             fret_ff, fret_in;
   logic signed [COORD_BITS-1:0] crd_ff;
   logic signed [COORD_BITS-1:0] cbuf_ff [4];
   logic signed [COORD_BITS-1:0] cbuf_in [4];

   logic signed [PNT_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [AREA_IDX_W-1:0]  def_ff, def_in;
   logic [16:0]            def_link_ff, def_link_in;
   logic                   gotdef_ff, gotdef_in;
   dif_type                ax_ff, ax_in, ay_ff, ay_in, r_ff, r_in;
   prod_type               acc_ff, acc_in;
   prod_type               prod_ff;
   mul_req_type            mul_req;

   logic signed [COORD_BITS-1:0] ex0_ff, ex0_in, ey0_ff, ey0_in;
   logic signed [COORD_BITS-1:0] ex1_ff, ex1_in, ey1_ff, ey1_in;
   logic signed [COORD_BITS-1:0] fx_ff, fx_in, fy_ff, fy_in;
   logic [VERT_W-1:0]      vleft_ff, vleft_in;
   logic                   closing_ff, closing_in;
   logic signed [WIND_W-1:0] wind_ff, wind_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic                   rsp_link_ff, rsp_link_in;
   logic [15:0]            rsp_id_ff, rsp_id_in;
   logic [4:0]             rsp_idx_ff, rsp_idx_in;

   logic                   beg_wr, end_wr, coord_wr;
   logic [1:0]             end_shape;
   logic [COORD_CNT_W-1:0] end_count;
   logic [COORD_CNT_W-1:0] fill_base;
   logic [COORD_CNT_W-1:0] cnt;
   logic                   end_ok;
   logic                   area_hit, area_miss;
   logic [AREA_CNT_W-1:0]  a_next;
   logic [AREA_IDX_W-1:0]  widx;
   dif_type                dx, dy, rr, adx, ady;
   logic signed [PROD_W:0] side;
   logic signed [WIND_W-1:0] wind_nx;
   logic [16:0]            fin_link;

   assign widx = area_total_ff[AREA_IDX_W-1:0];
   assign busy = (state_ff != S_IDLE);

   ihit_mul u_mul (
      .clock   (clock),
      .req     (mul_req),
      .prod_ff (prod_ff)
   );

   always_comb begin
      state_in      = state_ff;
      area_total_in = area_total_ff;
      coord_fill_in = coord_fill_ff;
      area_open_in  = area_open_ff;
      open_first_in = open_first_ff;
      pend_code_in  = pend_code_ff;
      a_in          = a_ff;
      ptr_in        = ptr_ff;
      left_in       = left_ff;
      pend_in       = pend_ff;
      fret_in       = fret_ff;
      cbuf_in       = cbuf_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      def_in        = def_ff;
      def_link_in   = def_link_ff;
      gotdef_in     = gotdef_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      r_in          = r_ff;
      acc_in        = acc_ff;
      ex0_in        = ex0_ff;
      ey0_in        = ey0_ff;
      ex1_in        = ex1_ff;
      ey1_in        = ey1_ff;
      fx_in         = fx_ff;
      fy_in         = fy_ff;
      vleft_in      = vleft_ff;
      closing_in    = closing_ff;
      wind_in       = wind_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_link_in   = rsp_link_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_idx_in    = rsp_idx_ff;
      mul_req       = '{en: 1'b0, a: '0, b: '0};
      beg_wr        = 1'b0;
      end_wr        = 1'b0;
      coord_wr      = 1'b0;
      area_hit      = 1'b0;
      area_miss     = 1'b0;
      fill_base     = area_open_ff ? open_first_ff : coord_fill_ff;
      cnt           = coord_fill_ff - open_first_ff;
      end_count     = cnt;
      end_ok        = 1'b1;
      dx            = dif_type'(px_ff) - dif_type'(cbuf_ff[1]);
      dy            = dif_type'(py_ff) - dif_type'(cbuf_ff[2]);
      rr            = dif_type'(cbuf_ff[3]);
      adx           = dx;
      ady           = dy;
      side          = (PROD_W + 1)'(acc_ff) - (PROD_W + 1)'(prod_ff);
      wind_nx       = wind_ff;
      a_next        = a_ff + AREA_CNT_W'(1);
      fin_link      = ard_link_ff;

      case (pend_code_ff)
         SC_UNSPEC: begin
            if (cnt == '0) begin
               end_shape = SH_DEFAULT;
            end else if (cnt == COORD_CNT_W'(3)) begin
               end_shape = SH_CIRCLE;
            end else if (cnt == COORD_CNT_W'(4)) begin
               end_shape = SH_RECT;
            end else begin
               end_shape = SH_POLY;
            end
         end
         SC_RECT:   end_shape = SH_RECT;
         SC_CIRCLE: end_shape = SH_CIRCLE;
         SC_POLY:   end_shape = SH_POLY;
         default:   end_shape = SH_DEFAULT;
      endcase
      if (end_shape == SH_RECT && cnt != COORD_CNT_W'(4)) begin
         end_ok = 1'b0;
      end
      if (end_shape == SH_CIRCLE && cnt != COORD_CNT_W'(3)) begin
         end_ok = 1'b0;
      end
      if (end_shape == SH_POLY) begin
         if (cnt == '0) begin
            end_ok = 1'b0;
         end else if (cnt[0]) begin
            end_count = cnt - COORD_CNT_W'(1);
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_status_in = ST_OK;
               rsp_hit_in    = 1'b0;
               rsp_link_in   = 1'b0;
               rsp_id_in     = '0;
               rsp_idx_in    = '0;
               rsp_valid_in  = 1'b1;
               case (req_mode)
                  MODE_CLEAR: begin
                     area_total_in = '0;
                     coord_fill_in = '0;
                     area_open_in  = 1'b0;
                  end
                  MODE_BEGIN: begin
                     coord_fill_in = fill_base;
                     area_open_in  = 1'b0;
                     if (area_total_ff >= AREA_CNT_W'(MAX_AREAS)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        pend_code_in  = req_shape_code;
                        open_first_in = fill_base;
                        area_open_in  = 1'b1;
                        beg_wr        = 1'b1;
                     end
                  end
                  MODE_APPEND: begin
                     if (!area_open_ff) begin
                        rsp_status_in = ST_NOAREA;
                     end else if (coord_fill_ff >= COORD_CNT_W'(MAX_COORDS)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        coord_wr      = 1'b1;
                        coord_fill_in = coord_fill_ff + COORD_CNT_W'(1);
                     end
                  end
                  MODE_END: begin
                     if (!area_open_ff) begin
                        rsp_status_in = ST_NOAREA;
                     end else begin
                        area_open_in = 1'b0;
                        if (!end_ok) begin
                           coord_fill_in = open_first_ff;
                           rsp_status_in = ST_REJECT;
                        end else begin
                           coord_fill_in = open_first_ff + end_count;
                           end_wr        = 1'b1;
                           area_total_in = area_total_ff + AREA_CNT_W'(1);
                        end
                     end
                  end
                  MODE_QUERY: begin
                     px_in     = PNT_W'(req_point_x) + PNT_W'(req_offset_x);
                     py_in     = PNT_W'(req_point_y) + PNT_W'(req_offset_y);
                     a_in      = '0;
                     gotdef_in = 1'b0;
                     if (area_total_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_AREA_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_AREA_RD: begin
            state_in = S_AREA;
         end
         S_AREA: begin
            ptr_in  = ard_first_ff;
            pend_in = 1'b0;
            case (ard_shape_ff)
               SH_DEFAULT: begin
                  def_in      = a_ff[AREA_IDX_W-1:0];
                  def_link_in = ard_link_ff;
                  gotdef_in   = 1'b1;
                  area_miss   = 1'b1;
               end
               SH_RECT: begin
                  left_in  = 3'd4;
                  fret_in  = S_RECT;
                  state_in = S_FETCH;
               end
               SH_CIRCLE: begin
                  left_in  = 3'd3;
                  fret_in  = S_CIRC;
                  state_in = S_FETCH;
               end
               default: begin
                  if (ard_count_ff[COORD_CNT_W-1:1] == '0) begin
                     area_miss = 1'b1;
                  end else begin
                     vleft_in   = ard_count_ff[COORD_CNT_W-1:1] - VERT_W'(1);
                     wind_in    = '0;
                     closing_in = 1'b0;
                     left_in    = 3'd2;
                     fret_in    = S_PV0;
                     state_in   = S_FETCH;
                  end
               end
            endcase
         end
         S_FETCH: begin
            if (pend_ff) begin
               cbuf_in[0] = cbuf_ff[1];
               cbuf_in[1] = cbuf_ff[2];
               cbuf_in[2] = cbuf_ff[3];
               cbuf_in[3] = crd_ff;
            end
            if (left_ff != '0) begin
               ptr_in  = ptr_ff + COORD_IDX_W'(1);
               left_in = left_ff - 3'd1;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = fret_ff;
               end
            end
         end
         S_RECT: begin
            if (px_ff >= cbuf_ff[0] && px_ff <= cbuf_ff[2] &&
                py_ff >= cbuf_ff[1] && py_ff <= cbuf_ff[3]) begin
               area_hit = 1'b1;
            end else begin
               area_miss = 1'b1;
            end
         end
         S_CIRC: begin
            if (dx < 0) begin
               adx = -dx;
            end
            if (dy < 0) begin
               ady = -dy;
            end
            if (rr < 0) begin
               rr = -rr;
            end
            ax_in = adx;
            ay_in = ady;
            r_in  = rr;
            if (adx > rr || ady > rr) begin
               area_miss = 1'b1;
            end else begin
               state_in = S_MUL_X;
            end
         end
         S_MUL_X: begin
            mul_req  = '{en: 1'b1, a: ax_ff, b: ax_ff};
            state_in = S_MUL_Y;
         end
         S_MUL_Y: begin
            mul_req  = '{en: 1'b1, a: ay_ff, b: ay_ff};
            acc_in   = prod_ff;
            state_in = S_MUL_R;
         end
         S_MUL_R: begin
            mul_req  = '{en: 1'b1, a: r_ff, b: r_ff};
            acc_in   = acc_ff + prod_ff;
            state_in = S_CIRC_CMP;
         end
         S_CIRC_CMP: begin
            if (acc_ff <= prod_ff) begin
               area_hit = 1'b1;
            end else begin
               area_miss = 1'b1;
            end
         end
         S_PV0: begin
            fx_in  = cbuf_ff[2];
            fy_in  = cbuf_ff[3];
            ex0_in = cbuf_ff[2];
            ey0_in = cbuf_ff[3];
            if (vleft_ff != '0) begin
               left_in  = 3'd2;
               pend_in  = 1'b0;
               fret_in  = S_PV;
               state_in = S_FETCH;
            end else begin
               ex1_in     = cbuf_ff[2];
               ey1_in     = cbuf_ff[3];
               closing_in = 1'b1;
               state_in   = S_E1;
            end
         end
         S_PV: begin
            ex1_in   = cbuf_ff[2];
            ey1_in   = cbuf_ff[3];
            vleft_in = vleft_ff - VERT_W'(1);
            state_in = S_E1;
         end
         S_E1: begin
            mul_req = '{en: 1'b1,
                        a: dif_type'(ex1_ff) - dif_type'(ex0_ff),
                        b: dif_type'(py_ff) - dif_type'(ey0_ff)};
            state_in = S_E2;
         end
         S_E2: begin
            acc_in  = prod_ff;
            mul_req = '{en: 1'b1,
                        a: dif_type'(px_ff) - dif_type'(ex0_ff),
                        b: dif_type'(ey1_ff) - dif_type'(ey0_ff)};
            state_in = S_E3;
         end
         S_E3: begin
            if (ey0_ff <= py_ff && py_ff < ey1_ff && side > 0) begin
               wind_nx = wind_ff + WIND_W'(1);
            end else if (ey1_ff <= py_ff && py_ff < ey0_ff && side < 0) begin
               wind_nx = wind_ff - WIND_W'(1);
            end
            wind_in = wind_nx;
            ex0_in  = ex1_ff;
            ey0_in  = ey1_ff;
            if (closing_ff) begin
               if (wind_nx != '0) begin
                  area_hit = 1'b1;
               end else begin
                  area_miss = 1'b1;
               end
            end else if (vleft_ff != '0) begin
               left_in  = 3'd2;
               pend_in  = 1'b0;
               fret_in  = S_PV;
               state_in = S_FETCH;
            end else begin
               ex1_in     = fx_ff;
               ey1_in     = fy_ff;
               closing_in = 1'b1;
               state_in   = S_E1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (area_hit) begin
         state_in      = S_IDLE;
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_OK;
         rsp_hit_in    = 1'b1;
         rsp_link_in   = fin_link[16];
         rsp_id_in     = fin_link[16] ? fin_link[15:0] : 16'd0;
         rsp_idx_in    = 5'(a_ff[AREA_IDX_W-1:0]);
      end else if (area_miss) begin
         if (a_next == area_total_ff) begin
            fin_link      = gotdef_in ? def_link_in : 17'd0;
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_hit_in    = gotdef_in;
            rsp_link_in   = fin_link[16];
            rsp_id_in     = fin_link[16] ? fin_link[15:0] : 16'd0;
            rsp_idx_in    = gotdef_in ? 5'(def_in) : 5'd0;
         end else begin
            a_in     = a_next;
            state_in = S_AREA_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         area_total_ff <= '0;
         coord_fill_ff <= '0;
         area_open_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         area_total_ff <= area_total_in;
         coord_fill_ff <= coord_fill_in;
         area_open_ff  <= area_open_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      open_first_ff <= open_first_in;
      pend_code_ff  <= pend_code_in;
      a_ff          <= a_in;
      ptr_ff        <= ptr_in;
      left_ff       <= left_in;
      pend_ff       <= pend_in;
      fret_ff       <= fret_in;
      cbuf_ff       <= cbuf_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      def_ff        <= def_in;
      def_link_ff   <= def_link_in;
      gotdef_ff     <= gotdef_in;
      ax_ff         <= ax_in;
      ay_ff         <= ay_in;
      r_ff          <= r_in;
      acc_ff        <= acc_in;
      ex0_ff        <= ex0_in;
      ey0_ff        <= ey0_in;
      ex1_ff        <= ex1_in;
      ey1_ff        <= ey1_in;
      fx_ff         <= fx_in;
      fy_ff         <= fy_in;
      vleft_ff      <= vleft_in;
      closing_ff    <= closing_in;
      wind_ff       <= wind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_link_ff   <= rsp_link_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_idx_ff    <= rsp_idx_in;
   end

   always_ff @(posedge clock) begin
      if (beg_wr) begin
         first_mem[widx] <= open_first_in[COORD_IDX_W-1:0];
         link_mem[widx]  <= {req_has_link, req_link_id};
      end
      if (end_wr) begin
         shape_mem[widx] <= end_shape;
         count_mem[widx] <= end_count;
      end
      ard_shape_ff <= shape_mem[a_ff[AREA_IDX_W-1:0]];
      ard_first_ff <= first_mem[a_ff[AREA_IDX_W-1:0]];
      ard_count_ff <= count_mem[a_ff[AREA_IDX_W-1:0]];
      ard_link_ff  <= link_mem[a_ff[AREA_IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (coord_wr) begin
         coord_mem[coord_fill_ff[COORD_IDX_W-1:0]] <= COORD_BITS'(req_coord_value);
      end
      crd_ff <= coord_mem[ptr_ff];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_hit_has_link   = rsp_link_ff;
   assign rsp_hit_link_id    = rsp_id_ff;
   assign rsp_hit_area_index = rsp_idx_ff;

   `ASSERT_AT_CLK(a_query_ends_in_rsp, ($fell(busy) |-> rsp_valid), "query ended without response")
   `ASSERT_AT_CLK(a_miss_no_link, (rsp_valid && !rsp_hit |-> rsp_hit_link_id == 16'd0), "miss with link")
   `ASSERT_NEVER(a_total_range, (area_total_ff > AREA_CNT_W'(MAX_AREAS)), "area count overflow")
   `ASSERT_AT_CLK(a_query_starts, (start && !busy && req_mode == MODE_QUERY |=> busy || rsp_valid), "query lost")

endmodule

/* design/ihit_mul.sv */
// Shared signed multiplier of the hit-test unit with a registered product.
// Depends on ihit_pkg.
module ihit_mul import ihit_pkg::*; (
   input  logic        clock,
   input  mul_req_type req,
   output prod_type    prod_ff
);

   always_ff @(posedge clock) begin
      if (req.en) begin
         prod_ff <= req.a * req.b;
      end
   end

endmodule

/* test/imagemap_area_hit_test_checker.sv */
// Checker of the image-map hit-test unit: watches the request and response ports,
// keeps its own copy of the area table, predicts every response and compares it.
// Depends on ihit_pkg; instantiated by imagemap_area_hit_test_unit_tb.
module imagemap_area_hit_test_checker import ihit_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [2:0]         req_mode,
   input  logic [2:0]         req_shape_code,
   input  logic               req_has_link,
   input  logic [15:0]        req_link_id,
   input  logic signed [15:0] req_coord_value,
   input  logic signed [15:0] req_point_x,
   input  logic signed [15:0] req_point_y,
   input  logic signed [15:0] req_offset_x,
   input  logic signed [15:0] req_offset_y,
   input  logic               rsp_valid,
   input  logic [1:0]         rsp_status,
   input  logic               rsp_hit,
   input  logic               rsp_hit_has_link,
   input  logic [15:0]        rsp_hit_link_id,
   input  logic [4:0]         rsp_hit_area_index,
   output int                 fail_count,
   output int                 awaited
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  status;
      logic        hit;
      logic        has_link;
      logic [15:0] link_id;
      logic [4:0]  area_index;
   } answer_type;

   answer_type         answer_q[$];
   logic [1:0]         shape_tab[MAX_AREAS];
   int                 first_tab[MAX_AREAS];
   int                 count_tab[MAX_AREAS];
   logic               link_flag_tab[MAX_AREAS];
   logic [15:0]        link_id_tab[MAX_AREAS];
   logic signed [15:0] coord_mem[MAX_COORDS];
   int                 area_cnt;
   int                 coord_cnt;
   bit                 area_is_open;
   logic [2:0]         open_code;

   function automatic longint coord(int i);
      return (i < MAX_COORDS) ? longint'(coord_mem[i]) : 0;
   endfunction

   function automatic bit poly_holds(int f, int cnt, longint px, longint py);
      int     nv;
      int     j;
      longint x0, y0, x1, y1, side, wind;
      nv = cnt / 2;
      wind = 0;
      for (int i = 0; i < nv; i++) begin
         j = (i + 1 == nv) ? 0 : i + 1;
         x0 = coord(f + 2 * i);
         y0 = coord(f + 2 * i + 1);
         x1 = coord(f + 2 * j);
         y1 = coord(f + 2 * j + 1);
         side = (x1 - x0) * (py - y0) - (px - x0) * (y1 - y0);
         if (y0 <= py && py < y1 && side > 0)
            wind++;
         else if (y1 <= py && py < y0 && side < 0)
            wind--;
      end
      return wind != 0;
   endfunction

   function automatic bit area_holds(int a, longint px, longint py);
      int     f;
      longint dx, dy, r;
      f = first_tab[a];
      case (shape_tab[a])
         SH_RECT: begin
            return px >= coord(f) && px <= coord(f + 2) &&
                   py >= coord(f + 1) && py <= coord(f + 3);
         end
         SH_CIRCLE: begin
            dx = px - coord(f);
            dy = py - coord(f + 1);
            r = coord(f + 2);
            return dx * dx + dy * dy <= r * r;
         end
         SH_POLY: return poly_holds(f, count_tab[a], px, py);
         default: return 0;
      endcase
   endfunction

   function automatic answer_type hit_test_step();
      answer_type ans;
      int         first, cnt, found, dflt;
      bit         ok, got, got_dflt;
      logic [1:0] sh;
      longint     px, py;
      ans = '0;
      case (req_mode)
         MODE_CLEAR: begin
            area_cnt = 0;
            coord_cnt = 0;
            area_is_open = 0;
         end
         MODE_BEGIN: begin
            if (area_is_open) begin
               coord_cnt = first_tab[area_cnt];
               area_is_open = 0;
            end
            if (area_cnt >= MAX_AREAS)
               ans.status = ST_FULL;
            else begin
               open_code = req_shape_code;
               first_tab[area_cnt] = coord_cnt;
               link_flag_tab[area_cnt] = req_has_link;
               link_id_tab[area_cnt] = req_link_id;
               area_is_open = 1;
            end
         end
         MODE_APPEND: begin
            if (!area_is_open)
               ans.status = ST_NOAREA;
            else if (coord_cnt >= MAX_COORDS)
               ans.status = ST_FULL;
            else begin
               coord_mem[coord_cnt] = req_coord_value;
               coord_cnt++;
            end
         end
         MODE_END: begin
            if (!area_is_open)
               ans.status = ST_NOAREA;
            else begin
               first = first_tab[area_cnt];
               cnt = coord_cnt - first;
               ok = 1;
               case (open_code)
                  SC_UNSPEC: sh = (cnt == 0) ? SH_DEFAULT : (cnt == 3) ? SH_CIRCLE :
                                  (cnt == 4) ? SH_RECT : SH_POLY;
                  SC_RECT:   sh = SH_RECT;
                  SC_CIRCLE: sh = SH_CIRCLE;
                  SC_POLY:   sh = SH_POLY;
                  default:   sh = SH_DEFAULT;
               endcase
               if (sh == SH_RECT && cnt != 4)
                  ok = 0;
               if (sh == SH_CIRCLE && cnt != 3)
                  ok = 0;
               if (sh == SH_POLY) begin
                  if (cnt == 0)
                     ok = 0;
                  else if (cnt % 2 == 1)
                     cnt--;
               end
               area_is_open = 0;
               if (!ok) begin
                  coord_cnt = first;
                  ans.status = ST_REJECT;
               end else begin
                  coord_cnt = first + cnt;
                  shape_tab[area_cnt] = sh;
                  count_tab[area_cnt] = cnt;
                  area_cnt++;
               end
            end
         end
         MODE_QUERY: begin
            px = longint'(req_point_x) + longint'(req_offset_x);
            py = longint'(req_point_y) + longint'(req_offset_y);
            got = 0;
            got_dflt = 0;
            found = 0;
            dflt = 0;
            for (int a = 0; a < area_cnt && !got; a++) begin
               if (shape_tab[a] == SH_DEFAULT) begin
                  dflt = a;
                  got_dflt = 1;
               end else if (area_holds(a, px, py)) begin
                  found = a;
                  got = 1;
               end
            end
            if (!got && got_dflt) begin
               found = dflt;
               got = 1;
            end
            if (got) begin
               ans.hit = 1;
               ans.has_link = link_flag_tab[found];
               ans.link_id = link_flag_tab[found] ? link_id_tab[found] : 16'd0;
               ans.area_index = found[4:0];
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         area_cnt <= 0;
         coord_cnt <= 0;
         area_is_open <= 0;
         answer_q.delete();
         fail_count <= 0;
         awaited <= 0;
      end else begin
         if (rsp_valid) begin
            if (answer_q.size() == 0) begin
               $error("response with no request outstanding");
               fail_count <= fail_count + 1;
            end else begin
               want = answer_q.pop_front();
               if (rsp_status !== want.status)
                  $error("status expected %0d got %0d", want.status, rsp_status);
               if (rsp_hit !== want.hit)
                  $error("hit expected %0d got %0d", want.hit, rsp_hit);
               if (rsp_hit_has_link !== want.has_link)
                  $error("hit_has_link expected %0d got %0d", want.has_link,
                         rsp_hit_has_link);
               if (rsp_hit_link_id !== want.link_id)
                  $error("hit_link_id expected %0d got %0d", want.link_id,
                         rsp_hit_link_id);
               if (rsp_hit_area_index !== want.area_index)
                  $error("hit_area_index expected %0d got %0d", want.area_index,
                         rsp_hit_area_index);
               if ({rsp_status, rsp_hit, rsp_hit_has_link, rsp_hit_link_id,
                    rsp_hit_area_index} !== want)
                  fail_count <= fail_count + 1;
            end
         end
         if (start && !busy)
            answer_q.push_back(hit_test_step());
         awaited <= answer_q.size();
      end
   end

endmodule

/* test/imagemap_area_hit_test_unit_tb.sv */
// Top of the image-map hit-test testbench: clock, reset, request stimulus and verdict.
// Depends on ihit_pkg, imagemap_area_hit_test_unit and imagemap_area_hit_test_checker.
module imagemap_area_hit_test_unit_tb import ihit_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_GOAL   = 700;
   localparam int QUIET_FROM  = 620;
   localparam int CYCLE_LIMIT = 4000000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_mode;
   logic [2:0]         req_shape_code;
   logic               req_has_link;
   logic [15:0]        req_link_id;
   logic signed [15:0] req_coord_value;
   logic signed [15:0] req_point_x;
   logic signed [15:0] req_point_y;
   logic signed [15:0] req_offset_x;
   logic signed [15:0] req_offset_y;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic               rsp_hit;
   logic               rsp_hit_has_link;
   logic [15:0]        rsp_hit_link_id;
   logic [4:0]         rsp_hit_area_index;
   int                 fail_count;
   int                 awaited;
   int                 cycles;
   int                 sent;

   imagemap_area_hit_test_unit dut (.*);

   imagemap_area_hit_test_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send(input logic [2:0] mode, input logic [2:0] code, input logic link,
                       input logic [15:0] id, input logic [15:0] cv, input logic [15:0] px,
                       input logic [15:0] py, input logic [15:0] ox, input logic [15:0] oy);
      req_mode <= mode;
      req_shape_code <= code;
      req_has_link <= link;
      req_link_id <= id;
      req_coord_value <= cv;
      req_point_x <= px;
      req_point_y <= py;
      req_offset_x <= ox;
      req_offset_y <= oy;
      start <= 1;
      do @(posedge clock); while (busy);
      sent++;
      if (sent < QUIET_FROM && $urandom_range(0, 5) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic open_area(input logic [2:0] code);
      send(MODE_BEGIN, code, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom);
   endtask

   task automatic add(input int v);
      send(MODE_APPEND, $urandom, $urandom, $urandom, v, $urandom, $urandom, $urandom,
           $urandom);
   endtask

   task automatic close_area();
      send(MODE_END, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom);
   endtask

   task automatic ask(input int x, input int y, input int ox, input int oy);
      send(MODE_QUERY, $urandom, $urandom, $urandom, $urandom, x, y, ox, oy);
   endtask

   function automatic int near();
      return $urandom_range(0, 9) == 0 ? int'($signed(16'($urandom)))
                                        : $urandom_range(0, 200) - 100;
   endfunction

   task automatic random_area();
      logic [2:0] code;
      int         n;
      code = $urandom_range(0, 7);
      case (code)
         SC_RECT:   n = 4;
         SC_CIRCLE: n = 3;
         SC_POLY:   n = $urandom_range(1, 12);
         SC_UNSPEC: n = $urandom_range(0, 1) ? 0 : $urandom_range(3, 10);
         default:   n = 0;
      endcase
      if ($urandom_range(0, 7) == 0)
         n = $urandom_range(0, 9);
      open_area(code);
      for (int i = 0; i < n; i++) begin
         if (code == SC_RECT && i >= 2 && $urandom_range(0, 3) != 0)
            add(near() + 100);
         else if ((code == SC_CIRCLE || (code == SC_UNSPEC && n == 3)) && i == 2)
            add($urandom_range(0, 60));
         else
            add(near());
      end
      if ($urandom_range(0, 19) != 0)
         close_area();
   endtask

   initial begin
      int pick;
      start = 0;
      reset = 1;
      cycles = 0;
      sent = 0;
      req_mode = MODE_CLEAR;
      req_shape_code = SC_UNSPEC;
      req_has_link = 0;
      req_link_id = 0;
      req_coord_value = 0;
      req_point_x = 0;
      req_point_y = 0;
      req_offset_x = 0;
      req_offset_y = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      ask(0, 0, 0, 0);
      add(5);
      close_area();
      send(3'd5, 0, 0, 0, 0, 0, 0, 0, 0);
      send(3'd7, 7, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      open_area(SC_RECT);
      add(-10); add(-10); add(10);
      close_area();
      open_area(SC_RECT);
      add(-10); add(-20); add(10); add(20);
      close_area();
      ask(10, 20, 0, 0);
      open_area(SC_UNSPEC);
      add(30); add(30); add(5);
      close_area();
      ask(30, 25, 0, 0);
      open_area(SC_POLY);
      close_area();
      open_area(3'd6);
      close_area();
      ask(32767, 32767, 32767, 32767);
      ask(-32768, -32768, -32768, -32768);
      send(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);

      while (sent < ITEM_GOAL) begin
         pick = $urandom_range(0, 99);
         if (pick < 2)
            send(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
         else if (pick < 6)
            send($urandom_range(2, 7), $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom);
         else if (pick < 40) begin
            if ($urandom_range(0, 7) == 0)
               ask($signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)),
                   $signed(16'($urandom)));
            else
               ask($urandom_range(0, 240) - 120, $urandom_range(0, 240) - 120,
                   $urandom_range(0, 20) - 10, $urandom_range(0, 20) - 10);
         end else
            random_area();
      end
      start <= 0;
      @(posedge clock);
      wait (awaited == 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
